// File: hw/rtl/kvi_pkg.sv
package kvi_pkg;

    // Width of the interpolation fraction (0.16)
    localparam int FRAC_W = 16;
    // Width of one coordinate / time word
    localparam int WORD_W = 32;

    // Result source codes
    typedef enum logic [1:0] {
        SRC_DEFAULT = 2'd0,
        SRC_FIRST   = 2'd1,
        SRC_INTERP  = 2'd2,
        SRC_LAST    = 2'd3
    } t_src;

    // Input item kinds
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [1:0] REG_DEFAULT_X = 2'd1;
    localparam logic [1:0] REG_DEFAULT_Y = 2'd2;
    localparam logic [1:0] REG_DEFAULT_Z = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_LAST,
        S_VAL_A,
        S_VAL_B,
        S_DIV,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

endpackage

// File: hw/rtl/kvi_frac_div.sv
// Restoring divider for the interpolation fraction: quo = floor(num * 2^16 / den),
// valid only when num < den. One quotient bit per cycle.
module kvi_frac_div
    import kvi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WORD_W-1:0]   i_num,
    input  logic [WORD_W-1:0]   i_den,
    output logic                o_done,
    output logic [FRAC_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_den;
    logic [FRAC_W-1:0]   r_quo;

    logic [WORD_W:0]     rem_sh;
    logic [WORD_W:0]     rem_sub;
    logic                ge;

    // One trial subtraction per cycle; remainder stays below den
    always_comb begin
        rem_sh  = {r_rem, 1'b0};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_quo <= {r_quo[FRAC_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: hw/rtl/keyframe_vector_interpolator.sv
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tdata: key_slot, key_time, key_x, key_y,
//                                         key_z, sample_time; tuser: mode
// m_axis    out  m_axis_tvalid/tready     tdata: out_x, out_y, out_z; tuser: source
// apb       in   psel/penable/pwrite      key_count, default_x, default_y, default_z
//
// A load is written to the key memories as it is accepted. A sample with an empty
// table goes straight to S_OUT; otherwise S_FIRST checks the first key and S_SCAN
// walks the keys, ending at S_LAST or, on finding the upper key, going through
// S_VAL_A, S_VAL_B, S_DIV and S_MUL/S_ADD per component. The single read port of
// the key memories sets the scan at one key per cycle; a fraction divider and one
// multiplier shared by the three components form the blend.
// Reset is synchronous and clears control state only; the key memories hold
// nothing until written. A stalled result holds in the output register while the
// next item is accepted; the sequencer waits only if a second result is ready.
module keyframe_vector_interpolator
    import kvi_pkg::*;
#(
    parameter int MAX_KEYS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,

    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // [3:0] key_slot, [35:4] key_time, [67:36] key_x, [99:68] key_y,
    // [131:100] key_z, [163:132] sample_time, [167:164] zero
    input  logic [167:0]   s_axis_tdata,
    // [0] mode
    input  logic [0:0]     s_axis_tuser,

    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [95:0]    m_axis_tdata,
    // [1:0] source
    output logic [1:0]     m_axis_tuser,

    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int VAL_W = 3 * WORD_W;

    // Configuration registers
    logic [4:0]          r_key_count;
    logic [WORD_W-1:0]   r_def_x;
    logic [WORD_W-1:0]   r_def_y;
    logic [WORD_W-1:0]   r_def_z;

    // Key memories
    logic [WORD_W-1:0]   mem_time [MAX_KEYS];
    logic [VAL_W-1:0]    mem_val  [MAX_KEYS];
    logic [WORD_W-1:0]   r_time_q;
    logic [VAL_W-1:0]    r_val_q;

    // Sequencer
    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_last;
    logic                r_one;
    logic [WORD_W-1:0]   r_st;
    logic [WORD_W-1:0]   r_prev_t;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_b;
    logic [1:0]          r_comp;
    logic signed [49:0]  r_prod;
    logic [VAL_W-1:0]    r_res;
    t_src                r_src;

    // Output register
    logic                r_m_valid;
    logic [VAL_W-1:0]    r_m_data;
    t_src                r_m_src;

    // Combinational
    logic                in_xfer;
    logic                cfg_wr;
    logic                load_we;
    logic [AW-1:0]       rd_addr;
    logic                div_start;
    logic                div_done;
    logic [FRAC_W-1:0]   div_quo;
    logic [WORD_W-1:0]   div_num;
    logic                found;
    logic                out_free;
    logic [WORD_W-1:0]   in_sample_time;
    logic [3:0]          in_slot;
    logic [AW-1:0]       cnt_last;
    logic [WORD_W-1:0]   comp_a;
    logic [WORD_W-1:0]   comp_b;
    logic signed [32:0]  comp_diff;
    logic signed [49:0]  prod_rnd;
    logic [WORD_W-1:0]   comp_res;

    assign in_xfer        = s_axis_tvalid && s_axis_tready;
    assign in_slot        = s_axis_tdata[3:0];
    assign in_sample_time = s_axis_tdata[163:132];
    assign load_we        = in_xfer && (s_axis_tuser[0] == MODE_LOAD)
                            && ({28'd0, in_slot} < 32'(MAX_KEYS));
    assign found          = (r_st < r_time_q);
    assign out_free       = !r_m_valid || m_axis_tready;
    assign cnt_last       = ({27'd0, r_key_count} >= 32'(MAX_KEYS)) ?
                            AW'(MAX_KEYS - 1) : AW'(5'(r_key_count - 5'd1));

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_def_x     <= '0;
            r_def_y     <= '0;
            r_def_z     <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_KEY_COUNT: r_key_count <= pwdata[4:0];
                REG_DEFAULT_X: r_def_x     <= pwdata;
                REG_DEFAULT_Y: r_def_y     <= pwdata;
                REG_DEFAULT_Z: r_def_z     <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_COUNT: prdata = {27'd0, r_key_count};
            REG_DEFAULT_X: prdata = r_def_x;
            REG_DEFAULT_Y: prdata = r_def_y;
            REG_DEFAULT_Z: prdata = r_def_z;
            default:       prdata = '0;
        endcase
    end

    // Key memories: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_time[AW'(in_slot)] <= s_axis_tdata[35:4];
        end
        r_time_q <= mem_time[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_val[AW'(in_slot)] <= s_axis_tdata[131:36];
        end
        r_val_q <= mem_val[rd_addr];
    end

    // Sample time before the lower key (unsorted table) gives a zero fraction
    assign div_num = (r_st < r_prev_t) ? '0 : (r_st - r_prev_t);

    // Fraction divider
    kvi_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_time_q - r_prev_t),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Component selection for the shared blend unit
    always_comb begin
        case (r_comp)
            2'd0:    begin comp_a = r_a[31:0];  comp_b = r_b[31:0];  end
            2'd1:    begin comp_a = r_a[63:32]; comp_b = r_b[63:32]; end
            default: begin comp_a = r_a[95:64]; comp_b = r_b[95:64]; end
        endcase
        comp_diff = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
        prod_rnd  = (r_prod + 50'sd32768) >>> 16;
        comp_res  = comp_a + prod_rnd[31:0];
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, read address and divider start
    always_comb begin
        n_state       = r_state;
        rd_addr       = r_idx;
        div_start     = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                rd_addr       = '0;
                if (in_xfer && (s_axis_tuser[0] == MODE_SAMPLE)) begin
                    n_state = (r_key_count == 5'd0) ? S_OUT : S_FIRST;
                end
            end
            S_FIRST: begin
                rd_addr = AW'(1);
                if (r_one || (r_st <= r_time_q)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (found) begin
                    rd_addr   = r_idx - 1'b1;
                    div_start = 1'b1;
                    n_state   = S_VAL_A;
                end else if (r_idx == r_last) begin
                    rd_addr = r_idx;
                    n_state = S_LAST;
                end else begin
                    rd_addr = r_idx + 1'b1;
                end
            end
            S_LAST:  n_state = S_OUT;
            S_VAL_A: begin
                rd_addr = r_idx;
                n_state = S_VAL_B;
            end
            S_VAL_B: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_comp == 2'd2) ? S_OUT : S_MUL;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_st   <= in_sample_time;
                r_one  <= (r_key_count == 5'd1);
                r_last <= cnt_last;
                r_res  <= {r_def_z, r_def_y, r_def_x};
                r_src  <= SRC_DEFAULT;
            end
            S_FIRST: begin
                r_res    <= r_val_q;
                r_src    <= SRC_FIRST;
                r_prev_t <= r_time_q;
                r_idx    <= AW'(1);
            end
            S_SCAN: begin
                if (!found && (r_idx != r_last)) begin
                    r_prev_t <= r_time_q;
                    r_idx    <= r_idx + 1'b1;
                end
            end
            S_LAST: begin
                r_res <= r_val_q;
                r_src <= SRC_LAST;
            end
            S_VAL_A: r_a <= r_val_q;
            S_VAL_B: begin
                r_b    <= r_val_q;
                r_comp <= 2'd0;
                r_src  <= SRC_INTERP;
            end
            S_MUL: r_prod <= comp_diff * $signed({1'b0, div_quo});
            S_ADD: begin
                case (r_comp)
                    2'd0:    r_res[31:0]  <= comp_res;
                    2'd1:    r_res[63:32] <= comp_res;
                    default: r_res[95:64] <= comp_res;
                endcase
                r_comp <= r_comp + 2'd1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_m_data <= r_res;
            r_m_src  <= r_src;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_src;

endmodule

// File: dv/keyframe_vector_interpolator_tb.sv
`timescale 1ns / 1ps

module keyframe_vector_interpolator_tb;
    import kvi_pkg::*;

    localparam int TABLE_DEPTH = 16;
    // scan plus divider plus shared multiplier, with some margin
    localparam int SETTLE_CYCLES = 48;
    localparam int SCENE_ITEMS = 90;

    typedef struct {
        logic              mode;
        logic [3:0]        slot;
        logic [31:0]       ktime;
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] kz;
        logic [31:0]       st;
    } t_key_item;

    typedef struct {
        logic signed [31:0] val [3];
        t_src               src;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [3:0] key_slot, [35:4] key_time, [67:36] key_x, [99:68] key_y,
    // [131:100] key_z, [163:132] sample_time, [167:164] zero
    logic [167:0] s_axis_tdata = '0;
    // [0] mode
    logic [0:0]   s_axis_tuser = '0;

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    logic [95:0]  m_axis_tdata;
    // [1:0] source
    logic [1:0]   m_axis_tuser;

    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    keyframe_vector_interpolator #(
        .MAX_KEYS (TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor copy of the keyframe table and registers
    logic [31:0]        key_time_tab [TABLE_DEPTH];
    logic signed [31:0] key_val_tab [TABLE_DEPTH][3];
    logic [4:0]         cfg_key_count = '0;
    logic signed [31:0] cfg_default [3] = '{32'sd0, 32'sd0, 32'sd0};

    // Stimulus bookkeeping: times as the generator last loaded them
    logic [31:0] scene_time [TABLE_DEPTH];

    t_key_item item_backlog [$];
    t_sample   samples_due [$];
    t_key_item item_on_bus;
    t_sample   result_want;

    int pushed_count = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 85;

    string comp_name [3] = '{"out_x", "out_y", "out_z"};

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #9_600_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Rounded blend a + (b - a) * f, f being a 0.16 fraction
    function automatic logic signed [31:0] lerp_word(logic signed [31:0] a,
                                                     logic signed [31:0] b, longint frac);
        longint d;
        longint p;
        d = longint'(b) - longint'(a);
        p = d * frac + 64'sd32768;
        return 32'(longint'(a) + (p >>> 16));
    endfunction

    // Expected output of one sample transfer
    function automatic t_sample sample_at(logic [31:0] st);
        t_sample r;
        int      n;
        longint  den;
        longint  num;
        longint  frac;
        n = (cfg_key_count > 5'd16) ? TABLE_DEPTH : int'(cfg_key_count);
        if (n == 0) begin
            r.val = cfg_default;
            r.src = SRC_DEFAULT;
            return r;
        end
        if (n == 1 || st <= key_time_tab[0]) begin
            r.val = key_val_tab[0];
            r.src = SRC_FIRST;
            return r;
        end
        for (int i = 0; i + 1 < n; i++) begin
            if (st < key_time_tab[i + 1]) begin
                den = longint'({32'b0, key_time_tab[i + 1]}) - longint'({32'b0, key_time_tab[i]});
                num = longint'({32'b0, st}) - longint'({32'b0, key_time_tab[i]});
                if (den <= 0 || num <= 0)
                    frac = 0;
                else if (num >= den)
                    frac = 65536;
                else
                    frac = (num * 65536) / den;
                for (int c = 0; c < 3; c++)
                    r.val[c] = lerp_word(key_val_tab[i][c], key_val_tab[i + 1][c], frac);
                r.src = SRC_INTERP;
                return r;
            end
        end
        r.val = key_val_tab[n - 1];
        r.src = SRC_LAST;
        return r;
    endfunction

    // Update the table on a load, queue the expected output on a sample
    function automatic void apply_item(t_key_item it);
        if (it.mode == MODE_LOAD) begin
            key_time_tab[it.slot] = it.ktime;
            key_val_tab[it.slot][0] = it.kx;
            key_val_tab[it.slot][1] = it.ky;
            key_val_tab[it.slot][2] = it.kz;
        end else begin
            samples_due = {samples_due, sample_at(it.st)};
        end
    endfunction

    // Value mix: extremes, full random and small magnitudes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        endcase
    endfunction

    function automatic void push_load(logic [3:0] slot, logic [31:0] t,
                                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_key_item it;
        it.mode = MODE_LOAD;
        it.slot = slot;
        it.ktime = t;
        it.kx = x;
        it.ky = y;
        it.kz = z;
        it.st = $urandom;
        scene_time[slot] = t;
        item_backlog = {item_backlog, it};
        pushed_count++;
    endfunction

    // Unused key fields carry noise on a sample
    function automatic void push_sample(logic [31:0] st);
        t_key_item it;
        it.mode = MODE_SAMPLE;
        it.slot = 4'($urandom);
        it.ktime = $urandom;
        it.kx = $urandom;
        it.ky = $urandom;
        it.kz = $urandom;
        it.st = st;
        item_backlog = {item_backlog, it};
        pushed_count++;
    endfunction

    // Sample time aimed at the interesting spots of the loaded keys
    function automatic logic [31:0] pick_time(int n);
        int i;
        if (n == 0)
            return $urandom;
        i = (n > 1) ? $urandom_range(0, n - 2) : 0;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, scene_time[0]);
            1: return scene_time[$urandom_range(0, n - 1)];
            2, 3, 4: return $urandom_range(scene_time[i], scene_time[i + 1 < n ? i + 1 : i]);
            5: return scene_time[n - 1] + $urandom_range(0, 255);
            6: return scene_time[i] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            7: return $urandom;
            8: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(scene_time[0], scene_time[n - 1]);
        endcase
    endfunction

    // Keys for slots below the count, then mostly samples with some reloads
    function automatic void run_scene(int kc);
        int          n;
        bit          unsorted;
        logic [31:0] t;
        n = (kc > TABLE_DEPTH) ? TABLE_DEPTH : kc;
        unsorted = ($urandom_range(0, 3) == 0);
        t = $urandom_range(0, 1) ? $urandom_range(0, 32'h8000_0000) : $urandom_range(0, 32'h10_0000);
        for (int s = 0; s < n; s++) begin
            if (unsorted) begin
                t = $urandom;
            end else if (s != 0) begin
                case ($urandom_range(0, 9))
                    0: t = t;
                    1, 2, 3: t = t + $urandom_range(1, 64);
                    4, 5, 6: t = t + $urandom_range(1, 32'h4_0000);
                    default: t = t + $urandom_range(1, 32'h0800_0000);
                endcase
            end
            push_load(4'(s), t, rand_word(), rand_word(), rand_word());
        end
        for (int k = n; k < SCENE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 8)
                push_load(4'($urandom_range(0, 15)), $urandom, rand_word(), rand_word(),
                          rand_word());
            else
                push_sample(pick_time(n));
        end
    endfunction

    // Hold the sender until every transfer is taken and every result is back
    task automatic settle();
        while (accepted_count != pushed_count || samples_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read-back
    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        logic [31:0] rb;
        logic [31:0] want;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEY_COUNT: cfg_key_count = value[4:0];
            REG_DEFAULT_X: cfg_default[0] = value;
            REG_DEFAULT_Y: cfg_default[1] = value;
            default:       cfg_default[2] = value;
        endcase
        want = (idx == REG_KEY_COUNT) ? {27'b0, value[4:0]} : value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rb = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rb !== want) begin
            $error("prdata[%0d]: expected %h, got %h", idx, want, rb);
            fail_count++;
        end
    endtask

    // Stimulus sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                apply_item(item_on_bus);
                accepted_count++;
            end
            if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item_on_bus = item_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, item_on_bus.st, item_on_bus.kz, item_on_bus.ky,
                                 item_on_bus.kx, item_on_bus.ktime, item_on_bus.slot};
                s_axis_tuser <= item_on_bus.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (samples_due.size() == 0) begin
                    $error("result transfer with none pending: %h / %0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    result_want = samples_due.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (m_axis_tdata[32 * c +: 32] !== result_want.val[c]) begin
                            $error("%s: expected %0d, got %0d", comp_name[c],
                                   result_want.val[c], $signed(m_axis_tdata[32 * c +: 32]));
                            fail_count++;
                        end
                    end
                    if (m_axis_tuser !== result_want.src) begin
                        $error("source: expected %0d, got %0d", result_want.src, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sequence of phases
    initial begin
        int kc;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table with reset defaults
        push_sample(32'h0);
        push_sample(32'hFFFF_FFFF);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd0);
        cfg_write(REG_DEFAULT_X, 32'h8000_0000);
        cfg_write(REG_DEFAULT_Y, 32'h7FFF_FFFF);
        cfg_write(REG_DEFAULT_Z, 32'h0000_0001);
        push_sample($urandom);

        // keys with extreme values, a repeated time and the top time
        push_load(4'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        push_load(4'd1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_load(4'd2, 32'h0003_0000, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0003);
        push_load(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd1);
        push_sample(32'hFFFF_FFFF);
        settle();
        cfg_write(REG_KEY_COUNT, 32'd4);
        push_sample(32'h0);
        push_sample(32'h0001_0000);
        push_sample(32'h0002_0000);
        push_sample(32'h0002_FFFF);
        push_sample(32'h0003_0000);
        push_sample(32'hFFFF_FFFE);
        push_sample(32'hFFFF_FFFF);
        // unsorted: slot 1 now earlier than slot 0
        push_load(4'd1, 32'h0000_8000, 32'h0000_1000, 32'hFFFF_F000, 32'h7FFF_0000);
        push_sample(32'h0002_0000);
        push_sample(32'h0000_4000);

        // random scenes under three idling regimes
        for (int ph = 0; ph < 12; ph++) begin
            settle();
            if (ph == 4) begin
                send_idle_pct <= 85;
                recv_idle_pct <= 9;
            end
            if (ph == 8) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (ph)
                0, 4, 11: kc = TABLE_DEPTH;
                2:        kc = 20;
                5:        kc = 1;
                7:        kc = 31;
                8:        kc = 2;
                10:       kc = 0;
                default:  kc = $urandom_range(2, 15);
            endcase
            cfg_write(REG_KEY_COUNT, 32'(kc));
            cfg_write(REG_DEFAULT_X, rand_word());
            cfg_write(REG_DEFAULT_Y, rand_word());
            cfg_write(REG_DEFAULT_Z, rand_word());
            run_scene(kc);
        end

        for (int w = 0; w < 200000 && (accepted_count != pushed_count || samples_due.size() != 0);
             w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (accepted_count != pushed_count || samples_due.size() != 0) begin
            $error("%0d results never arrived", samples_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
